@@ hw/rtl/svla_pkg.sv @@
package svla_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // input item codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_NOTE_ON = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd5;

  // slots of the per-leg sample counts
  localparam logic [1:0] N_ATT = 2'd0;
  localparam logic [1:0] N_DEC = 2'd1;
  localparam logic [1:0] N_SUS = 2'd2;
  localparam logic [1:0] N_REL = 2'd3;

  localparam logic [DATA_W-1:0] MS_PER_SEC  = 32'd1000;
  localparam logic [MS_W-1:0]   RATE_RESET  = 16'd22050;
  localparam logic [14:0]       SAMPLE_MAX  = 15'h7fff;
  localparam logic [DATA_W-1:0] HOLD_ALWAYS = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] phase_step;
    logic [MS_W-1:0]   sustain_ms;
    logic              hold_forever;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
  } out_item_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_CNT_GO,
    ST_CNT_WAIT,
    ST_REL_GO,
    ST_REL_WAIT,
    ST_LO_MUL,
    ST_DEC_GO,
    ST_DEC_WAIT,
    ST_HI_MUL,
    ST_ATT_GO,
    ST_ATT_WAIT,
    ST_ENV_MUL,
    ST_COMMIT
  } seq_state_e;

endpackage

@@ hw/rtl/svla_div.sv @@
module svla_div
  import svla_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  // one restoring step: shift in the next dividend bit and try to subtract
  always_comb begin
    shifted = {rem_q, quo_q[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    if (!diff[DATA_W+1]) begin
      rem_d = diff[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hw/rtl/square_voice_linear_adsr.sv @@
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    in_data_i  (in_item_t)
// out       out  out_valid_o / out_ready_i  out_data_o (out_item_t)
// cfg       in   cfg_we_i, no wait          cfg_idx_i, cfg_data_i
//
// a tick passes from idle through ST_TICK, a release is taken in its accept cycle
// a note on runs from the accept cycle through seven 32-bit divisions in the
// shared radix-2 divider and four multiply and commit steps
// in_ready_o is high only while the sequencer is idle
// a tick waits in ST_TICK while the output register still holds a result
// reset clears all voice state; the voice starts silent, sample rate 22050
module square_voice_linear_adsr
  import svla_pkg::*;
#(
  parameter int unsigned LEVEL_SHIFT = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  // configuration registers
  logic [MS_W-1:0]   attack_ms_q, decay_ms_q, release_ms_q, sample_rate_q;
  logic [DATA_W-1:0] attack_level_q, sustain_level_q;

  // voice state
  logic [DATA_W-1:0] phase_q, phase_inc_q, env_q, slope_q, hold_q, sus_cnt_q;
  logic [DATA_W-1:0] peak_q, sus_tgt_q, decay_slope_q, rel_slope_q;

  // note-on scratch
  logic [DATA_W-1:0] step_q;
  logic [MS_W-1:0]   sus_ms_q;
  logic              forever_q;
  logic [1:0]        idx_q;
  logic [DATA_W-1:0] n_q [4];
  logic [DATA_W-1:0] down_r_q, down_d_q, up_q, lo_q, hi_q, mul_q;

  logic      out_valid_q;
  out_item_t out_q;

  seq_state_e state_q, state_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_xfer;
  logic              out_free;
  logic [MS_W-1:0]   ms_sel;
  logic [DATA_W-1:0] q_min1;
  logic [DATA_W-1:0] mul_a, mul_b, mul_p;
  logic [DATA_W-1:0] lo_dec_sum, hi_sel;

  // tick datapath
  logic [DATA_W-1:0] phase_n, env_n, slope_n, hold_n, env_sum, level_w;
  logic [14:0]       level_sat;
  logic [15:0]       level_pos;

  svla_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign q_min1 = (div_rsp.quotient == '0) ? DATA_W'(1) : div_rsp.quotient;

  // leg time chosen for the count being converted
  always_comb begin
    unique case (idx_q)
      N_ATT:   ms_sel = attack_ms_q;
      N_DEC:   ms_sel = decay_ms_q;
      N_SUS:   ms_sel = sus_ms_q;
      default: ms_sel = release_ms_q;
    endcase
  end

  // decay leg must span at least one step per sample
  assign lo_dec_sum = lo_q + n_q[N_DEC];
  assign hi_sel     = (attack_level_q < lo_dec_sum) ? lo_dec_sum : attack_level_q;

  // shared multiplier operands
  always_comb begin
    unique case (state_q)
      ST_LO_MUL: begin
        mul_a = down_r_q;
        mul_b = n_q[N_REL];
      end
      ST_HI_MUL: begin
        mul_a = down_d_q;
        mul_b = n_q[N_DEC];
      end
      default: begin
        mul_a = up_q;
        mul_b = n_q[N_ATT];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DATA_W'(ms_sel) * DATA_W'(sample_rate_q);
    div_req.divisor  = MS_PER_SEC;
    unique case (state_q)
      ST_CNT_GO: div_req.start = 1'b1;
      ST_REL_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sustain_level_q;
        div_req.divisor  = n_q[N_REL];
      end
      ST_DEC_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = hi_sel - lo_q;
        div_req.divisor  = n_q[N_DEC];
      end
      ST_ATT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = lo_q + mul_q;
        div_req.divisor  = n_q[N_ATT];
      end
      default: ;
    endcase
  end

  // one tick of phase and envelope
  always_comb begin
    phase_n = phase_q + phase_inc_q;
    env_sum = env_q + slope_q;
    env_n   = env_q;
    slope_n = slope_q;
    hold_n  = hold_q;
    if (hold_q != '0) begin
      hold_n = hold_q - 1'b1;
    end else if (slope_q != '0) begin
      env_n = env_sum;
      priority if (env_sum == peak_q) begin
        slope_n = decay_slope_q;
      end else if (env_sum == sus_tgt_q) begin
        slope_n = rel_slope_q;
        hold_n  = sus_cnt_q;
      end else if (env_sum == '0) begin
        slope_n = '0;
      end
    end
    level_w   = env_n >> LEVEL_SHIFT;
    level_sat = (level_w > DATA_W'(SAMPLE_MAX)) ? SAMPLE_MAX : level_w[14:0];
    level_pos = {1'b0, level_sat};
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.op == OP_TICK) begin
            state_d = ST_TICK;
          end else if (in_data_i.op == OP_NOTE_ON) begin
            state_d = ST_CNT_GO;
          end
        end
      end
      ST_TICK:     if (out_free) state_d = ST_IDLE;
      ST_CNT_GO:   state_d = ST_CNT_WAIT;
      ST_CNT_WAIT: begin
        if (div_rsp.done) state_d = (idx_q == N_REL) ? ST_REL_GO : ST_CNT_GO;
      end
      ST_REL_GO:   state_d = ST_REL_WAIT;
      ST_REL_WAIT: if (div_rsp.done) state_d = ST_LO_MUL;
      ST_LO_MUL:   state_d = ST_DEC_GO;
      ST_DEC_GO:   state_d = ST_DEC_WAIT;
      ST_DEC_WAIT: if (div_rsp.done) state_d = ST_HI_MUL;
      ST_HI_MUL:   state_d = ST_ATT_GO;
      ST_ATT_GO:   state_d = ST_ATT_WAIT;
      ST_ATT_WAIT: if (div_rsp.done) state_d = ST_ENV_MUL;
      ST_ENV_MUL:  state_d = ST_COMMIT;
      ST_COMMIT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_ms_q     <= '0;
      attack_level_q  <= '0;
      decay_ms_q      <= '0;
      sustain_level_q <= '0;
      release_ms_q    <= '0;
      sample_rate_q   <= RATE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACK_MS:     attack_ms_q     <= cfg_data_i[MS_W-1:0];
        REG_ATTACK_LEVEL:  attack_level_q  <= cfg_data_i;
        REG_DECAY_MS:      decay_ms_q      <= cfg_data_i[MS_W-1:0];
        REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data_i;
        REG_RELEASE_MS:    release_ms_q    <= cfg_data_i[MS_W-1:0];
        REG_SAMPLE_RATE:   sample_rate_q   <= cfg_data_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_TICK && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TICK && out_free) begin
      if (phase_inc_q == '0 || env_n == '0) begin
        out_q.sample <= '0;
        out_q.active <= 1'b0;
      end else begin
        out_q.sample <= phase_n[DATA_W-1] ? level_pos : 16'd0 - level_pos;
        out_q.active <= 1'b1;
      end
    end
  end

  // note-on scratch registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      step_q    <= in_data_i.phase_step;
      sus_ms_q  <= in_data_i.sustain_ms;
      forever_q <= in_data_i.hold_forever;
    end
    if (state_q == ST_CNT_WAIT && div_rsp.done) n_q[idx_q] <= q_min1;
    if (state_q == ST_REL_WAIT && div_rsp.done) down_r_q <= q_min1;
    if (state_q == ST_DEC_WAIT && div_rsp.done) down_d_q <= q_min1;
    if (state_q == ST_ATT_WAIT && div_rsp.done) up_q <= q_min1;
    if (state_q == ST_LO_MUL) lo_q <= mul_p;
    if (state_q == ST_ATT_GO) hi_q <= div_req.dividend;
    if (state_q == ST_LO_MUL || state_q == ST_HI_MUL || state_q == ST_ENV_MUL) begin
      mul_q <= mul_p;
    end
  end

  // count index walks attack, decay, sustain, release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= N_ATT;
    end else if (in_xfer) begin
      idx_q <= N_ATT;
    end else if (state_q == ST_CNT_WAIT && div_rsp.done) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      phase_inc_q   <= '0;
      env_q         <= '0;
      slope_q       <= '0;
      hold_q        <= '0;
      sus_cnt_q     <= '0;
      peak_q        <= '0;
      sus_tgt_q     <= '0;
      decay_slope_q <= '0;
      rel_slope_q   <= '0;
    end else begin
      if (in_xfer && in_data_i.op == OP_RELEASE) begin
        hold_q    <= '0;
        sus_cnt_q <= '0;
      end
      if (state_q == ST_TICK && out_free && phase_inc_q != '0) begin
        phase_q <= phase_n;
        env_q   <= env_n;
        slope_q <= slope_n;
        hold_q  <= hold_n;
        if (env_n == '0) phase_inc_q <= '0;
      end
      if (state_q == ST_COMMIT) begin
        env_q         <= hi_q - mul_q;
        slope_q       <= up_q;
        hold_q        <= '0;
        sus_cnt_q     <= forever_q ? HOLD_ALWAYS : n_q[N_SUS];
        peak_q        <= hi_q;
        sus_tgt_q     <= lo_q;
        decay_slope_q <= '0 - down_d_q;
        rel_slope_q   <= '0 - down_r_q;
        phase_q       <= '0;
        phase_inc_q   <= step_q;
      end
    end
  end

endmodule

@@ verif/adsr_voice_checker.sv @@
module adsr_voice_checker
  import svla_pkg::*;
#(
  parameter int unsigned LEVEL_SHIFT = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // voice settings as last written
  logic [MS_W-1:0]   attack_ms;
  logic [DATA_W-1:0] attack_level;
  logic [MS_W-1:0]   decay_ms;
  logic [DATA_W-1:0] sustain_level;
  logic [MS_W-1:0]   release_ms;
  logic [MS_W-1:0]   sample_rate;

  // oscillator and envelope state
  logic [DATA_W-1:0] phase;
  logic [DATA_W-1:0] phase_inc;
  logic [DATA_W-1:0] env_level;
  logic [DATA_W-1:0] env_slope;
  logic [DATA_W-1:0] hold_count;
  logic [DATA_W-1:0] sustain_count;
  logic [DATA_W-1:0] peak_level;
  logic [DATA_W-1:0] floor_level;
  logic [DATA_W-1:0] decay_step;
  logic [DATA_W-1:0] release_step;

  // samples still owed by the voice, oldest first
  out_item_t expected_samples[$];

  task automatic report_mismatch(string what, int got, int want);
    errors_o++;
    if (errors_o <= 100) begin
      $display("%0t ns: sample mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic clear_voice();
    attack_ms = '0;
    attack_level = '0;
    decay_ms = '0;
    sustain_level = '0;
    release_ms = '0;
    sample_rate = RATE_RESET;
    phase = '0;
    phase_inc = '0;
    env_level = '0;
    env_slope = '0;
    hold_count = '0;
    sustain_count = '0;
    peak_level = '0;
    floor_level = '0;
    decay_step = '0;
    release_step = '0;
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    case (idx)
      REG_ATTACK_MS:     attack_ms = val[MS_W-1:0];
      REG_ATTACK_LEVEL:  attack_level = val;
      REG_DECAY_MS:      decay_ms = val[MS_W-1:0];
      REG_SUSTAIN_LEVEL: sustain_level = val;
      REG_RELEASE_MS:    release_ms = val[MS_W-1:0];
      REG_SAMPLE_RATE:   sample_rate = val[MS_W-1:0];
      default: ;
    endcase
  endtask

  // milliseconds to samples, never below one sample
  function automatic logic [DATA_W-1:0] samples_for(logic [MS_W-1:0] ms);
    logic [DATA_W-1:0] n;
    n = ({16'd0, ms} * {16'd0, sample_rate}) / MS_PER_SEC;
    return (n == '0) ? 32'd1 : n;
  endfunction

  // leg steps and levels so that every leg lands exactly on its target
  task automatic start_note(in_item_t it);
    logic [DATA_W-1:0] n_att, n_dec, n_sus, n_rel;
    logic [DATA_W-1:0] lo, hi, up, down_d, down_r;
    n_att = samples_for(attack_ms);
    n_dec = samples_for(decay_ms);
    n_sus = samples_for(it.sustain_ms);
    n_rel = samples_for(release_ms);
    down_r = sustain_level / n_rel;
    if (down_r == '0) down_r = 32'd1;
    lo = down_r * n_rel;
    hi = attack_level;
    if (hi < lo + n_dec) hi = lo + n_dec;
    down_d = (hi - lo) / n_dec;
    if (down_d == '0) down_d = 32'd1;
    hi = lo + down_d * n_dec;
    up = hi / n_att;
    if (up == '0) up = 32'd1;
    env_level = hi - up * n_att;
    env_slope = up;
    hold_count = '0;
    sustain_count = it.hold_forever ? HOLD_ALWAYS : n_sus;
    peak_level = hi;
    floor_level = lo;
    decay_step = 32'd0 - down_d;
    release_step = 32'd0 - down_r;
    phase = '0;
    phase_inc = it.phase_step;
  endtask

  task automatic advance_envelope();
    if (hold_count != '0) begin
      hold_count = hold_count - 32'd1;
    end else if (env_slope != '0) begin
      env_level = env_level + env_slope;
      if (env_level == peak_level) begin
        env_slope = decay_step;
      end else if (env_level == floor_level) begin
        env_slope = release_step;
        hold_count = sustain_count;
      end else if (env_level == '0) begin
        env_slope = '0;
      end
    end
  endtask

  // one tick: square sign from phase msb, magnitude from the envelope
  task automatic predict_tick();
    out_item_t r;
    logic [DATA_W-1:0] level;
    r = '0;
    if (phase_inc != '0) begin
      phase = phase + phase_inc;
      advance_envelope();
      if (env_level == '0) begin
        phase_inc = '0;
      end else begin
        level = env_level >> LEVEL_SHIFT;
        if (level > 32'd32767) level = 32'd32767;
        r.sample = phase[31] ? level[15:0] : 16'(32'd0 - level);
        r.active = 1'b1;
      end
    end
    expected_samples.push_back(r);
  endtask

  task automatic take_item(in_item_t it);
    case (it.op)
      OP_TICK:    predict_tick();
      OP_NOTE_ON: start_note(it);
      OP_RELEASE: begin
        sustain_count = '0;
        hold_count = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_sample(out_item_t got);
    out_item_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch("sample with none expected", int'(got.sample), 0);
    end else begin
      want = expected_samples.pop_front();
      if (got.sample !== want.sample) begin
        report_mismatch("sample", int'(got.sample), int'(want.sample));
      end
      if (got.active !== want.active) begin
        report_mismatch("active", int'(got.active), int'(want.active));
      end
    end
  endtask

  // watch all three ports at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_voice();
      expected_samples.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_sample(out_data_i);
      if (cfg_we_i) write_setting(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_i) take_item(in_data_i);
    end
    pending_o = expected_samples.size();
  end

endmodule

@@ verif/testbench.sv @@
module testbench;
  import svla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHIFT       = 17;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  // a note on keeps the block busy, with no sample, until its commit
  localparam int unsigned NOTE_SETTLE = 300;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 200;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  int unsigned pending;
  int unsigned errors;
  bit          quiet = 1'b0;
  int unsigned long_holds_wanted = 0;
  int unsigned cycles = 0;

  square_voice_linear_adsr #(
    .LEVEL_SHIFT(SHIFT)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  adsr_voice_checker #(
    .LEVEL_SHIFT(SHIFT)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sample receiver: random stall bursts, long hold-offs on request
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (long_holds_wanted > holds_done) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        holds_done++;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  function automatic in_item_t tick_item();
    in_item_t it;
    it.op = OP_TICK;
    it.phase_step = $urandom;
    it.sustain_ms = MS_W'($urandom_range(0, 65535));
    it.hold_forever = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t release_item();
    in_item_t it;
    it = tick_item();
    it.op = OP_RELEASE;
    return it;
  endfunction

  function automatic in_item_t note_item(logic [DATA_W-1:0] step, logic [MS_W-1:0] sus,
                                         logic hold_all);
    in_item_t it;
    it.op = OP_NOTE_ON;
    it.phase_step = step;
    it.sustain_ms = sus;
    it.hold_forever = hold_all;
    return it;
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(tick_item());
  endtask

  // drain all owed samples, then let a pending note on finish
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (NOTE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic program_voice(logic [MS_W-1:0] att_ms, logic [DATA_W-1:0] att_level,
                               logic [MS_W-1:0] dec_ms, logic [DATA_W-1:0] sus_level,
                               logic [MS_W-1:0] rel_ms, logic [MS_W-1:0] rate);
    write_reg(REG_ATTACK_MS, DATA_W'(att_ms));
    write_reg(REG_ATTACK_LEVEL, att_level);
    write_reg(REG_DECAY_MS, DATA_W'(dec_ms));
    write_reg(REG_SUSTAIN_LEVEL, sus_level);
    write_reg(REG_RELEASE_MS, DATA_W'(rel_ms));
    write_reg(REG_SAMPLE_RATE, DATA_W'(rate));
  endtask

  // settings families: short legs, tiny levels, zero rate, full peak
  task automatic load_profile(int unsigned profile);
    logic [DATA_W-1:0] att_level, sus_level;
    att_level = $urandom;
    sus_level = $urandom;
    case (profile)
      0: program_voice(MS_W'($urandom_range(0, 8)), att_level, MS_W'($urandom_range(0, 8)),
                       sus_level, MS_W'($urandom_range(0, 8)), 16'd1000);
      1: begin
        if ($urandom_range(0, 1) == 0) att_level = $urandom_range(0, 200);
        if ($urandom_range(0, 1) == 0) sus_level = $urandom_range(0, 200);
        program_voice(MS_W'($urandom_range(0, 4)), att_level, MS_W'($urandom_range(0, 4)),
                      sus_level, MS_W'($urandom_range(0, 4)),
                      ($urandom_range(0, 1) == 0) ? 16'd1 : MS_W'($urandom_range(2, 4000)));
      end
      2: program_voice(MS_W'($urandom_range(0, 65535)), att_level,
                       MS_W'($urandom_range(0, 65535)), sus_level,
                       MS_W'($urandom_range(0, 65535)), 16'd0);
      default: program_voice(MS_W'($urandom_range(0, 3)), HOLD_ALWAYS,
                             MS_W'($urandom_range(0, 3)), sus_level,
                             MS_W'($urandom_range(0, 3)), MS_W'($urandom_range(1, 65535)));
    endcase
  endtask

  // mostly whole notes: note on, a run of ticks, maybe a release; some noise
  task automatic run_phase(int unsigned profile, int unsigned n_items);
    int unsigned sent, n_ticks, rel_at;
    logic [DATA_W-1:0] step;
    logic [MS_W-1:0] sus;
    logic hold_all;
    in_item_t junk;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 9))
          0:       step = '0;
          1, 2, 3: step = $urandom;
          default: step = $urandom_range(1, 32'h0800_0000);
        endcase
        case ($urandom_range(0, 15))
          0:       sus = 16'hffff;
          1:       sus = MS_W'($urandom_range(0, 65535));
          default: sus = MS_W'($urandom_range(0, 6));
        endcase
        hold_all = ($urandom_range(0, 3) == 0);
        n_ticks = $urandom_range(1, 50);
        rel_at = (hold_all || $urandom_range(0, 2) == 0) ? $urandom_range(0, n_ticks - 1)
                                                          : n_ticks;
        send_item(note_item(step, sus, hold_all));
        sent++;
        for (int unsigned i = 0; i < n_ticks; i++) begin
          if (i == rel_at) begin
            send_item(release_item());
            sent++;
          end
          send_item(tick_item());
          sent++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: send_item(tick_item());
          1: send_item(release_item());
          default: begin
            junk = tick_item();
            junk.op = OP_UNUSED;
            send_item(junk);
            sent--;
          end
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    in_item_t junk;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: idle voice, unused op, release while idle, silent note,
    // then a held note with zero levels that runs out after release
    send_item(tick_item());
    junk = '1;
    junk.op = OP_UNUSED;
    send_item(junk);
    send_item(release_item());
    send_item(note_item('0, '0, 1'b0));
    send_ticks(1);
    send_item(note_item(32'hffff_ffff, 16'hffff, 1'b1));
    send_ticks(3);
    send_item(release_item());
    send_ticks(2);

    // every setting at its maximum
    settle();
    program_voice(16'hffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff, 16'hffff);
    send_item(note_item(32'd1, '0, 1'b0));
    send_ticks(2);
    send_item(note_item(32'h8000_0000, '0, 1'b0));
    send_ticks(2);

    // zero sample rate: every leg one sample long
    settle();
    program_voice(MS_W'($urandom_range(0, 65535)), $urandom, MS_W'($urandom_range(0, 65535)),
                  $urandom, MS_W'($urandom_range(0, 65535)), 16'd0);
    send_item(note_item($urandom, '0, 1'b0));
    send_ticks(4);

    // random phases, each starting from a drained voice
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      load_profile(p % 4);
      if (p == 2 || p == 5) long_holds_wanted++;
      if (p == PHASES - 1) quiet = 1'b1;
      run_phase(p % 4, PHASE_ITEMS);
    end

    // drain and give the verdict
    settle();
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
